// ===== hw/rtl/bpa_pkg.sv =====
// Package for the bump pool allocator: field widths, kind and status codes,
// and the structs passed between the register block and the allocator core.
// No dependencies.
package bpa_pkg;

   localparam int unsigned ADDR_W     = 32;
   localparam int unsigned OFFSET_W   = 17;
   localparam int unsigned COUNT_W    = 32;
   localparam int unsigned LATE_W     = 16;
   localparam int unsigned ALIGN_W    = 3;
   localparam int unsigned MASK_W     = 7;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_IDX_W  = 1;

   localparam int unsigned POOL_SIZE_MAX_DEFAULT = 65536;
   localparam int unsigned OFFSET_MAX = (1 << OFFSET_W) - 1;

   typedef enum logic [1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_SEAL  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_GRANTED  = 3'd0,
      ST_OVERFLOW = 3'd1,
      ST_ZERO     = 3'd2,
      ST_REWOUND  = 3'd3,
      ST_IGNORED  = 3'd4,
      ST_HEAP     = 3'd5,
      ST_SEALED   = 3'd6
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POOL_BASE  = 1'd0,
      CSR_POOL_BYTES = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   pool_base;
      logic [OFFSET_W-1:0] capacity;
   } cfg_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [OFFSET_W-1:0] size;
      logic [ALIGN_W-1:0]  align_log2;
      logic [ADDR_W-1:0]   address;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [ADDR_W-1:0]   block_address;
      logic [OFFSET_W-1:0] used_bytes;
      logic [OFFSET_W-1:0] peak_bytes;
      logic [COUNT_W-1:0]  overflow_total;
      logic [LATE_W-1:0]   late_allocations;
   } rsp_type;

endpackage

// ===== hw/rtl/bpa_csr.sv =====
// Configuration registers of the bump pool allocator and the clamped pool
// capacity derived from them. Depends on bpa_pkg.
module bpa_csr #(
   parameter int unsigned POOL_SIZE_MAX = bpa_pkg::POOL_SIZE_MAX_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [bpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output bpa_pkg::cfg_type                cfg
);

   // The capacity register can never exceed the offset range, so the limit
   // only bites when it is below that range.
   localparam int unsigned LIMIT =
      (POOL_SIZE_MAX > bpa_pkg::OFFSET_MAX) ? bpa_pkg::OFFSET_MAX : POOL_SIZE_MAX;
   localparam logic [bpa_pkg::OFFSET_W-1:0] LIMIT_V = bpa_pkg::OFFSET_W'(LIMIT);

   logic [bpa_pkg::ADDR_W-1:0]   pool_base_ff;
   logic [bpa_pkg::ADDR_W-1:0]   pool_base_in;
   logic [bpa_pkg::OFFSET_W-1:0] pool_bytes_ff;
   logic [bpa_pkg::OFFSET_W-1:0] pool_bytes_in;

   always_comb begin
      pool_base_in  = pool_base_ff;
      pool_bytes_in = pool_bytes_ff;
      if (csr_write_enable) begin
         unique case (bpa_pkg::csr_index_type'(csr_index))
            bpa_pkg::CSR_POOL_BASE:  pool_base_in  = csr_write_data[bpa_pkg::ADDR_W-1:0];
            bpa_pkg::CSR_POOL_BYTES: pool_bytes_in = csr_write_data[bpa_pkg::OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff  <= '0;
         pool_bytes_ff <= bpa_pkg::OFFSET_W'(65536);
      end else begin
         pool_base_ff  <= pool_base_in;
         pool_bytes_ff <= pool_bytes_in;
      end
   end

   assign cfg.pool_base = pool_base_ff;
   assign cfg.capacity  = (pool_bytes_ff < LIMIT_V) ? pool_bytes_ff : LIMIT_V;

endmodule

// ===== hw/rtl/bpa_core.sv =====
// Allocator core: request register, allocator state with its update logic,
// and the result register. Depends on bpa_pkg.
module bpa_core (
   input  logic             clock,
   input  logic             reset,
   input  bpa_pkg::cfg_type cfg,
   input  logic             req_accept,
   input  bpa_pkg::req_type req,
   output logic             rsp_valid,
   output bpa_pkg::rsp_type rsp
);

   localparam int unsigned OW = bpa_pkg::OFFSET_W;
   localparam int unsigned AW = bpa_pkg::ADDR_W;
   localparam int unsigned CW = bpa_pkg::COUNT_W;
   localparam int unsigned LW = bpa_pkg::LATE_W;
   localparam int unsigned MW = bpa_pkg::MASK_W;

   logic             req_valid_ff;
   bpa_pkg::req_type req_ff;

   logic [OW-1:0] bump_ff,      bump_in;
   logic [OW-1:0] peak_ff,      peak_in;
   logic [CW-1:0] overflow_ff,  overflow_in;
   logic [LW-1:0] late_ff,      late_in;
   logic          sealed_ff,    sealed_in;
   logic [AW-1:0] last_addr_ff, last_addr_in;
   logic [OW-1:0] last_prior_ff, last_prior_in;
   logic          last_valid_ff, last_valid_in;

   logic             rsp_valid_ff;
   bpa_pkg::rsp_type rsp_ff, rsp_in;

   logic [MW-1:0] align_mask;
   logic [OW:0]   start_off;
   logic [OW+1:0] end_off;
   logic          fits;
   logic [AW-1:0] grant_addr;
   logic [CW:0]   overflow_sum;
   logic [AW:0]   pool_end;
   logic          in_pool;
   logic          late_bump;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req;
      end
   end

   // Offset arithmetic: round up, then check the end against the capacity
   // without any wrap.
   always_comb begin
      align_mask   = MW'((8'd1 << req_ff.align_log2) - 8'd1);
      start_off    = ({1'b0, bump_ff} + {{(OW+1-MW){1'b0}}, align_mask})
                     & ~{{(OW+1-MW){1'b0}}, align_mask};
      end_off      = {1'b0, start_off} + {2'b00, req_ff.size};
      fits         = (cfg.capacity != '0) && (end_off <= {2'b00, cfg.capacity});
      grant_addr   = cfg.pool_base + AW'(start_off);
      overflow_sum = {1'b0, overflow_ff} + {{(CW+1-OW){1'b0}}, req_ff.size};
      pool_end     = {1'b0, cfg.pool_base} + {{(AW+1-OW){1'b0}}, cfg.capacity};
      in_pool      = (cfg.capacity != '0) && (req_ff.address >= cfg.pool_base)
                     && ({1'b0, req_ff.address} < pool_end);
      late_bump    = sealed_ff && (late_ff != {LW{1'b1}});
   end

   always_comb begin
      bump_in       = bump_ff;
      peak_in       = peak_ff;
      overflow_in   = overflow_ff;
      late_in       = late_ff;
      sealed_in     = sealed_ff;
      last_addr_in  = last_addr_ff;
      last_prior_in = last_prior_ff;
      last_valid_in = last_valid_ff;
      rsp_in.status        = bpa_pkg::ST_IGNORED;
      rsp_in.block_address = '0;

      if (req_valid_ff) begin
         case (bpa_pkg::kind_type'(req_ff.kind))
            bpa_pkg::KIND_ALLOC: begin
               if (req_ff.size == '0) begin
                  rsp_in.status = bpa_pkg::ST_ZERO;
               end else begin
                  if (late_bump) begin
                     late_in = late_ff + LW'(1);
                  end
                  if (fits) begin
                     rsp_in.status        = bpa_pkg::ST_GRANTED;
                     rsp_in.block_address = grant_addr;
                     last_addr_in         = grant_addr;
                     last_prior_in        = bump_ff;
                     last_valid_in        = 1'b1;
                     bump_in              = end_off[OW-1:0];
                     if (end_off[OW-1:0] > peak_ff) begin
                        peak_in = end_off[OW-1:0];
                     end
                  end else begin
                     rsp_in.status = bpa_pkg::ST_OVERFLOW;
                     overflow_in   = overflow_sum[CW] ? {CW{1'b1}} : overflow_sum[CW-1:0];
                  end
               end
            end
            bpa_pkg::KIND_FREE: begin
               if (!in_pool) begin
                  rsp_in.status = bpa_pkg::ST_HEAP;
               end else if (last_valid_ff && (req_ff.address == last_addr_ff)) begin
                  rsp_in.status = bpa_pkg::ST_REWOUND;
                  bump_in       = last_prior_ff;
                  last_valid_in = 1'b0;
               end
            end
            bpa_pkg::KIND_SEAL: begin
               rsp_in.status = bpa_pkg::ST_SEALED;
               sealed_in     = 1'b1;
            end
            default: ;
         endcase
      end

      rsp_in.used_bytes       = bump_in;
      rsp_in.peak_bytes       = peak_in;
      rsp_in.overflow_total   = overflow_in;
      rsp_in.late_allocations = late_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bump_ff       <= '0;
         peak_ff       <= '0;
         overflow_ff   <= '0;
         late_ff       <= '0;
         sealed_ff     <= 1'b0;
         last_addr_ff  <= '0;
         last_prior_ff <= '0;
         last_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         bump_ff       <= bump_in;
         peak_ff       <= peak_in;
         overflow_ff   <= overflow_in;
         late_ff       <= late_in;
         sealed_ff     <= sealed_in;
         last_addr_ff  <= last_addr_in;
         last_prior_ff <= last_prior_in;
         last_valid_ff <= last_valid_in;
         rsp_valid_ff  <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== hw/rtl/bump_pool_allocator.sv =====
// Top level of the bump pool allocator: configuration registers and the
// allocator core. Depends on bpa_pkg, bpa_csr and bpa_core.
//
// The block takes one request per clock cycle: busy is never raised, so a
// request is taken at every edge where start is high. Its result appears
// as a single-cycle beat marked by rsp_valid, once it has passed the
// request register and the result register that sit either side of the
// update of the allocator state. The receiver cannot hold a result off and
// must take every beat as it appears. Pool registers are written through
// the csr_ port and take effect on the next request; they should only be
// changed while no request is in flight.
module bump_pool_allocator #(
   parameter int unsigned POOL_SIZE_MAX = bpa_pkg::POOL_SIZE_MAX_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_kind,
   input  logic [bpa_pkg::OFFSET_W-1:0]      req_size,
   input  logic [bpa_pkg::ALIGN_W-1:0]       req_align_log2,
   input  logic [bpa_pkg::ADDR_W-1:0]        req_address,
   output logic                              rsp_valid,
   output logic [2:0]                        rsp_status,
   output logic [bpa_pkg::ADDR_W-1:0]        rsp_block_address,
   output logic [bpa_pkg::OFFSET_W-1:0]      rsp_used_bytes,
   output logic [bpa_pkg::OFFSET_W-1:0]      rsp_peak_bytes,
   output logic [bpa_pkg::COUNT_W-1:0]       rsp_overflow_total,
   output logic [bpa_pkg::LATE_W-1:0]        rsp_late_allocations,
   input  logic                              csr_write_enable,
   input  logic [bpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   bpa_pkg::cfg_type cfg;
   bpa_pkg::req_type req;
   bpa_pkg::rsp_type rsp;

   assign busy = 1'b0;

   assign req.kind       = req_kind;
   assign req.size       = req_size;
   assign req.align_log2 = req_align_log2;
   assign req.address    = req_address;

   bpa_csr #(
      .POOL_SIZE_MAX (POOL_SIZE_MAX)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   bpa_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_accept (start && !busy),
      .req        (req),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp)
   );

   assign rsp_status           = rsp.status;
   assign rsp_block_address    = rsp.block_address;
   assign rsp_used_bytes       = rsp.used_bytes;
   assign rsp_peak_bytes       = rsp.peak_bytes;
   assign rsp_overflow_total   = rsp.overflow_total;
   assign rsp_late_allocations = rsp.late_allocations;

endmodule

// ===== hw/rtl/bpa_checker.sv =====
// Port-level checks for the bump pool allocator, bound to the top level.
// Depends on bpa_pkg and bump_pool_allocator.
module bpa_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [2:0]                        rsp_status,
   input logic [bpa_pkg::ADDR_W-1:0]        rsp_block_address,
   input logic [bpa_pkg::OFFSET_W-1:0]      rsp_used_bytes,
   input logic [bpa_pkg::OFFSET_W-1:0]      rsp_peak_bytes
);

   // No beat may appear in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat straight after reset");

   // Every accepted request yields its result beat.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("accepted request produced no result beat");

   // Only a grant carries a block address.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != bpa_pkg::ST_GRANTED)) |-> (rsp_block_address == '0))
      else $error("block address on a result that is not a grant");

   // The offset only rises through grants, which also lift the peak.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_used_bytes <= rsp_peak_bytes))
      else $error("used bytes above peak");

endmodule

bind bump_pool_allocator bpa_checker u_bpa_checker (.*);
